[rtl/crc32c_word_stream_defines.svh]
// assertion macros for the crc32c word stream block
// expects aclk and aresetn in the scope of each use
`ifndef CRC32C_WORD_STREAM_DEFINES_SVH
`define CRC32C_WORD_STREAM_DEFINES_SVH

// checked only while out of reset
`define CRC32C_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define CRC32C_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/crc32c_pkg.sv]
// shared constants and the crc-32c update matrix for the word stream block
// no dependencies
`default_nettype none

package crc32c_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] CRC_POLY_REFL = 32'h82F6_3B78;
    localparam logic [WORD_W-1:0] CRC_SEED_RESET = 32'hBABA_7007;

    // apb register map, one 32-bit register at byte address 0
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned REG_IDX_LSB = 2;
    localparam logic REG_IDX_SEED = 1'b0;

    typedef logic [WORD_W-1:0] crc_cols_t [WORD_W];

    // column i: the 32-shift update applied to a lone one in bit i
    function automatic logic [WORD_W-1:0] crc_column(input int unsigned bit_idx);
        logic [WORD_W-1:0] c;
        c = '0;
        c[bit_idx] = 1'b1;
        for (int unsigned k = 0; k < WORD_W; k++) begin
            c = (c >> 1) ^ (CRC_POLY_REFL & {WORD_W{c[0]}});
        end
        return c;
    endfunction

    function automatic crc_cols_t build_cols();
        crc_cols_t t;
        for (int unsigned i = 0; i < WORD_W; i++) begin
            t[i] = crc_column(i);
        end
        return t;
    endfunction

    localparam crc_cols_t CRC_COLS = build_cols();

endpackage

`default_nettype wire

[rtl/crc32c_word_stream.sv]
// crc32c_word_stream: running crc-32c over a stream of 32-bit words, apb seed register
// depends on crc32c_pkg and crc32c_word_stream_defines.svh
//
// One word is taken per clock. A word is captured in an input register, then a
// single xor tree (the 32x32 crc-32c update matrix, reflected poly 0x82F63B78, no
// inversion) folds it into the running crc, and a last word puts the crc in the
// output register. Sustained rate is one word per cycle, limited only by m_ready
// backpressure on last words. A first word starts from the crc_seed register
// (apb offset 0x0, reset 0xBABA7007); a word without first continues from the
// previous crc, which is zero after reset.
`default_nettype none

`include "crc32c_word_stream_defines.svh"

module crc32c_word_stream (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // word input
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [crc32c_pkg::WORD_W-1:0]        s_data_word,
    input  wire logic                                 s_first_word,
    input  wire logic                                 s_last_word,
    // crc output
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [crc32c_pkg::WORD_W-1:0]             m_crc_value,
    // apb config
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [crc32c_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    logic [crc32c_pkg::WORD_W-1:0] seed_reg;
    logic [crc32c_pkg::WORD_W-1:0] running_crc_reg, running_crc_next;

    logic                          in_valid_reg;
    logic [crc32c_pkg::WORD_W-1:0] in_word_reg;
    logic                          in_first_reg;
    logic                          in_last_reg;

    logic                          out_valid_reg;
    logic [crc32c_pkg::WORD_W-1:0] out_crc_reg;

    logic                          advance;
    logic                          cfg_write;
    logic                          seed_sel;
    logic [crc32c_pkg::WORD_W-1:0] crc_in;

    // apb
    assign pready    = 1'b1;
    assign seed_sel  = (paddr[crc32c_pkg::REG_IDX_LSB] == crc32c_pkg::REG_IDX_SEED);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = seed_sel ? seed_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= crc32c_pkg::CRC_SEED_RESET;
        end else if (cfg_write && seed_sel) begin
            seed_reg <= pwdata;
        end
    end

    // input stage moves on unless it holds a last word and the output is full
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg  <= s_data_word;
            in_first_reg <= s_first_word;
            in_last_reg  <= s_last_word;
        end
    end

    // word update as one xor tree over the matrix columns
    assign crc_in = (in_first_reg ? seed_reg : running_crc_reg) ^ in_word_reg;

    always_comb begin
        running_crc_next = '0;
        for (int unsigned i = 0; i < crc32c_pkg::WORD_W; i++) begin
            running_crc_next = running_crc_next
                             ^ (crc32c_pkg::CRC_COLS[i] & {crc32c_pkg::WORD_W{crc_in[i]}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg <= '0;
        end else if (advance) begin
            running_crc_reg <= running_crc_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_crc_reg <= running_crc_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_crc_value = out_crc_reg;

    `CRC32C_ASSERT_ALWAYS(a_reset_clears_crc,
        !aresetn |=> (running_crc_reg == '0),
        "running crc not cleared by reset")
    `CRC32C_ASSERT(a_stall_only_on_full_out,
        !s_ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_ready),
        "input stalled without a blocked last word")
    `CRC32C_ASSERT(a_new_result_from_last,
        (m_valid && !$past(m_valid && !m_ready)) |-> $past(advance && in_last_reg),
        "result beat without a last word")
    `CRC32C_ASSERT(a_seed_write,
        (cfg_write && seed_sel) |=> (seed_reg == $past(pwdata)),
        "seed register not written")

endmodule

`default_nettype wire

[tb/sv/crc32c_word_stream_tb.sv]
// self-checking testbench for crc32c_word_stream: directed and random word streams,
// random stalls on both sides, seed register writes and read-back over apb
// depends on crc32c_pkg and the crc32c_word_stream rtl
`default_nettype none

module crc32c_word_stream_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WORD_W = crc32c_pkg::WORD_W;
    localparam int unsigned PADDR_W = crc32c_pkg::PADDR_W;
    localparam int unsigned REG_IDX_SPARE = 1;  // no register here, writes are dropped
    localparam logic [PADDR_W-1:0] SEED_ADDR =
        PADDR_W'(crc32c_pkg::REG_IDX_SEED) << crc32c_pkg::REG_IDX_LSB;
    localparam logic [PADDR_W-1:0] SPARE_ADDR =
        PADDR_W'(REG_IDX_SPARE) << crc32c_pkg::REG_IDX_LSB;
    localparam int unsigned MAX_GAP = 14;
    localparam int unsigned LONG_HOLD = 120;
    localparam int unsigned DRAIN_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned PHASE_WORDS = 150;

    // running crc-32c per message plus the queue of crcs still owed by the block
    class crc32c_tracker;
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] running;
        logic [WORD_W-1:0] expected_crcs[$];
        int unsigned errors;

        function new();
            seed = crc32c_pkg::CRC_SEED_RESET;
            running = '0;
            errors = 0;
        endfunction

        // word xored in, then 32 reflected shifts
        function logic [WORD_W-1:0] fold_word(logic [WORD_W-1:0] crc, logic [WORD_W-1:0] w);
            logic [WORD_W-1:0] c;
            c = crc ^ w;
            repeat (WORD_W) c = (c >> 1) ^ (c[0] ? crc32c_pkg::CRC_POLY_REFL : '0);
            return c;
        endfunction

        function void write_reg(int unsigned index, logic [31:0] value);
            if (index == int'(crc32c_pkg::REG_IDX_SEED)) seed = value;
        endfunction

        function void note_word(logic [WORD_W-1:0] w, bit first, bit last);
            running = fold_word(first ? seed : running, w);
            if (last) expected_crcs.push_back(running);
        endfunction

        function void check_crc(logic [WORD_W-1:0] actual);
            logic [WORD_W-1:0] want;
            if (expected_crcs.size() == 0) begin
                $display("%0t: crc beat with none pending, expected none, actual %08h",
                         $time, actual);
                errors++;
            end else begin
                want = expected_crcs.pop_front();
                if (want !== actual) begin
                    $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_crcs.size();
        endfunction

        function void check_leftover();
            if (expected_crcs.size() != 0) begin
                $display("%0t: %0d crc beats missing, expected %08h first, actual none",
                         $time, expected_crcs.size(), expected_crcs[0]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [WORD_W-1:0]     s_data_word;
    logic                  s_first_word;
    logic                  s_last_word;
    logic                  m_valid;
    logic                  m_ready;
    logic [WORD_W-1:0]     m_crc_value;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    bit tx_gaps;
    bit rx_gaps;

    crc32c_tracker crc_track = new();

    crc32c_word_stream u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_first_word (s_first_word),
        .s_last_word  (s_last_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_crc_value  (m_crc_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("crc32c_word_stream_tb NOT OK");
        $finish;
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        crc_track.write_reg(32'(addr >> crc32c_pkg::REG_IDX_LSB), value);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check_seed();
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= SEED_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== crc_track.seed) begin
            $display("%0t: crc_seed read-back mismatch, expected %08h, actual %08h",
                     $time, crc_track.seed, prdata);
            crc_track.errors++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_word(input logic [WORD_W-1:0] w, input bit first, input bit last);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_word <= w;
        s_first_word <= first;
        s_last_word <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        crc_track.note_word(w, first, last);
    endtask

    // drop valid, wait for owed crcs, then let the pipeline settle
    task automatic drain();
        int unsigned n;
        n = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (crc_track.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return WORD_W'($urandom_range(0, 255));  // zero-extended tail byte
            1: return '0;
            2: return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly whole messages, some loose words with random first/last flags
    task automatic random_words(input int unsigned count);
        int unsigned left;
        int unsigned len;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                push_word(pick_word(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                left--;
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(1, 8);
                if (len > left) len = left;
                for (int unsigned i = 0; i < len; i++) begin
                    push_word(pick_word(), i == 0, i == len - 1);
                end
                left -= len;
            end
        end
    endtask

    // result side: random stalls, plus two long hold-offs to back up the input
    initial begin : crc_sink
        int unsigned stall;
        int unsigned beats;
        m_ready = 1'b0;
        beats = 0;
        @(posedge aresetn);
        forever begin
            if (beats == 60 || beats == 300) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            stall = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            crc_track.check_crc(m_crc_value);
            beats++;
            @(negedge aclk);
        end
    end

    initial begin : word_source
        logic [31:0] seed_val;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_word = '0;
        s_first_word = 1'b0;
        s_last_word = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apb_check_seed();
        // no first word since reset: starts from zero, not the seed
        push_word(32'h1234_5678, 1'b0, 1'b1);
        push_word(32'h0000_0000, 1'b1, 1'b1);
        // continues from the crc just emitted
        push_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_word(32'h8000_0001, 1'b0, 1'b0);
        push_word(32'h0000_00A5, 1'b0, 1'b1);
        drain();

        apb_write(SEED_ADDR, 32'h0000_0000);
        apb_write(SPARE_ADDR, 32'h1234_5678);
        apb_check_seed();
        push_word(32'h0000_0000, 1'b1, 1'b1);
        push_word(32'hA5A5_A5A5, 1'b1, 1'b0);
        push_word(32'h5A5A_5A5A, 1'b0, 1'b0);
        drain();

        // new seed mid-message only applies from the next first word
        apb_write(SEED_ADDR, 32'hFFFF_FFFF);
        apb_check_seed();
        push_word(32'h0000_00FF, 1'b0, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        push_word(32'h0000_0001, 1'b1, 1'b1);
        drain();

        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: seed_val = crc32c_pkg::CRC_SEED_RESET;
                1: seed_val = 32'h0000_0000;
                2: seed_val = 32'hFFFF_FFFF;
                default: seed_val = $urandom;
            endcase
            apb_write(SEED_ADDR, seed_val);
            if ($urandom_range(0, 3) == 0) apb_write(SPARE_ADDR, $urandom);
            apb_check_seed();
            if (ph == 3) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end else begin
                tx_gaps = $urandom_range(0, 2) != 0;
                rx_gaps = $urandom_range(0, 2) != 0;
            end
            random_words(PHASE_WORDS);
            drain();
        end

        crc_track.check_leftover();
        if (crc_track.errors == 0) begin
            $display("crc32c_word_stream_tb OK");
        end else begin
            $display("crc32c_word_stream_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
